// ----- rtl/core/imu_avg_pkg.sv -----
// ----------------------------------------------------------------------------
// imu_avg_pkg
// Shared widths, constants and control types for the IMU average decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_avg_pkg;

  localparam int SAMPLE_BITS  = 32;
  localparam int COUNT_BITS   = 20;
  localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
  localparam int CFG_BITS     = 20;
  localparam int PHASE_BITS   = CFG_BITS + 1;
  localparam int STAMP_BITS   = 48;
  localparam int AXES         = 6;
  localparam int AXIS_BITS    = $clog2(AXES);
  localparam int CFG_IDX_BITS = 2;

  localparam int DIV_BITS     = 4;
  localparam int DIV_STEPS    = (SUM_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W        = DIV_STEPS * DIV_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_TICK   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_OUTPUT = CFG_IDX_BITS'(1);

  localparam logic [CFG_BITS-1:0] TICK_RESET   = CFG_BITS'(1000);
  localparam logic [CFG_BITS-1:0] OUTPUT_RESET = CFG_BITS'(50000);

  localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  localparam logic [SAMPLE_BITS-1:0] MEAN_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] MEAN_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [DIV_W-1:0] MEAN_MAX_MAG = DIV_W'(MEAN_MAX);
  localparam logic [DIV_W-1:0] MEAN_MIN_MAG = DIV_W'(MEAN_MIN);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [PHASE_BITS-1:0] PHASE_MAX = {PHASE_BITS{1'b1}};

  localparam logic [AXIS_BITS-1:0] AXIS_LAST = AXIS_BITS'(AXES - 1);

  typedef logic [AXES-1:0][SAMPLE_BITS-1:0] axis_vec_t;
  typedef logic [AXES-1:0][SUM_BITS-1:0]    sum_vec_t;

  typedef struct packed {
    logic                 accum;
    logic                 div_start;
    logic                 store_mean;
    logic                 load_out;
    logic [AXIS_BITS-1:0] axis;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
    logic out_full;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/imu_avg_ifs.sv -----
// ----------------------------------------------------------------------------
// imu_avg_ifs
// Valid/ready channel interfaces for IMU samples and averaged results.
// ----------------------------------------------------------------------------
`default_nettype none

interface imu_avg_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [imu_avg_pkg::SAMPLE_BITS-1:0] accel_x;
  logic signed [imu_avg_pkg::SAMPLE_BITS-1:0] accel_y;
  logic signed [imu_avg_pkg::SAMPLE_BITS-1:0] accel_z;
  logic signed [imu_avg_pkg::SAMPLE_BITS-1:0] rate_x;
  logic signed [imu_avg_pkg::SAMPLE_BITS-1:0] rate_y;
  logic signed [imu_avg_pkg::SAMPLE_BITS-1:0] rate_z;

  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                output ready);
endinterface

interface imu_avg_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [imu_avg_pkg::SAMPLE_BITS-1:0] mean_accel_x;
  logic signed [imu_avg_pkg::SAMPLE_BITS-1:0] mean_accel_y;
  logic signed [imu_avg_pkg::SAMPLE_BITS-1:0] mean_accel_z;
  logic signed [imu_avg_pkg::SAMPLE_BITS-1:0] mean_rate_x;
  logic signed [imu_avg_pkg::SAMPLE_BITS-1:0] mean_rate_y;
  logic signed [imu_avg_pkg::SAMPLE_BITS-1:0] mean_rate_z;
  logic        [imu_avg_pkg::STAMP_BITS-1:0]  stamp_us;

  modport source (output valid, mean_accel_x, mean_accel_y, mean_accel_z,
                  mean_rate_x, mean_rate_y, mean_rate_z, stamp_us,
                  input ready);
  modport sink (input valid, mean_accel_x, mean_accel_y, mean_accel_z,
                mean_rate_x, mean_rate_y, mean_rate_z, stamp_us,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/imu_avg_divider.sv -----
// ----------------------------------------------------------------------------
// imu_avg_divider
// Radix-16 restoring divider: signed sum over unsigned count, result clamped
// to the sample range and truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_avg_divider (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic [imu_avg_pkg::SUM_BITS-1:0]     dividend,
  input  wire logic [imu_avg_pkg::COUNT_BITS-1:0]   divisor,
  output logic                                      done,
  output logic      [imu_avg_pkg::SAMPLE_BITS-1:0]  quotient
);

  logic [imu_avg_pkg::DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                                 done_r, done_nxt;
  logic [imu_avg_pkg::COUNT_BITS-1:0]   rem_r, rem_nxt;
  logic [imu_avg_pkg::COUNT_BITS-1:0]   div_r, div_nxt;
  logic [imu_avg_pkg::DIV_W-1:0]        quo_r, quo_nxt;
  logic                                 neg_r, neg_nxt;
  logic [imu_avg_pkg::COUNT_BITS-1:0]   step_rem;
  logic [imu_avg_pkg::DIV_W-1:0]        step_quo;
  logic [imu_avg_pkg::DIV_W-1:0]        mag;

  always_comb begin
    logic [imu_avg_pkg::COUNT_BITS:0] r_sh;
    step_rem = rem_r;
    step_quo = quo_r;
    for (int k = 0; k < imu_avg_pkg::DIV_BITS; k++) begin
      r_sh     = {step_rem, step_quo[imu_avg_pkg::DIV_W-1]};
      step_quo = {step_quo[imu_avg_pkg::DIV_W-2:0], 1'b0};
      if (r_sh >= {1'b0, div_r}) begin
        r_sh        = r_sh - {1'b0, div_r};
        step_quo[0] = 1'b1;
      end
      step_rem = r_sh[imu_avg_pkg::COUNT_BITS-1:0];
    end
  end

  always_comb begin
    mag = imu_avg_pkg::DIV_W'(dividend);
    if (dividend[imu_avg_pkg::SUM_BITS-1]) begin
      mag = imu_avg_pkg::DIV_W'(~dividend + imu_avg_pkg::SUM_BITS'(1));
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    if (start) begin
      cnt_nxt = imu_avg_pkg::DIV_CNT_BITS'(imu_avg_pkg::DIV_STEPS);
      rem_nxt = '0;
      div_nxt = divisor;
      quo_nxt = mag;
      neg_nxt = dividend[imu_avg_pkg::SUM_BITS-1];
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - imu_avg_pkg::DIV_CNT_BITS'(1);
      rem_nxt  = step_rem;
      quo_nxt  = step_quo;
      done_nxt = (cnt_r == imu_avg_pkg::DIV_CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    if (neg_r) begin
      if (quo_r > imu_avg_pkg::MEAN_MIN_MAG) begin
        quotient = imu_avg_pkg::MEAN_MIN;
      end else begin
        quotient = ~quo_r[imu_avg_pkg::SAMPLE_BITS-1:0] + imu_avg_pkg::SAMPLE_BITS'(1);
      end
    end else begin
      if (quo_r > imu_avg_pkg::MEAN_MAX_MAG) begin
        quotient = imu_avg_pkg::MEAN_MAX;
      end else begin
        quotient = quo_r[imu_avg_pkg::SAMPLE_BITS-1:0];
      end
    end
  end

  assign done = done_r;

endmodule

`default_nettype wire

// ----- rtl/core/imu_avg_datapath.sv -----
// ----------------------------------------------------------------------------
// imu_avg_datapath
// Axis sums, sample count, time and phase registers, the shared divider and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_avg_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire imu_avg_pkg::ctrl_cmd_t                 cmd,
  output imu_avg_pkg::dp_status_t                     status,
  input  wire logic                                   cfg_we,
  input  wire logic [imu_avg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [imu_avg_pkg::CFG_BITS-1:0]       cfg_data,
  input  wire imu_avg_pkg::axis_vec_t                 samples,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output imu_avg_pkg::axis_vec_t                      out_means,
  output logic      [imu_avg_pkg::STAMP_BITS-1:0]     out_stamp
);

  logic [imu_avg_pkg::CFG_BITS-1:0]   tick_r, tick_nxt;
  logic [imu_avg_pkg::CFG_BITS-1:0]   period_r, period_nxt;
  imu_avg_pkg::sum_vec_t              sums_r, sums_nxt;
  logic [imu_avg_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic [imu_avg_pkg::STAMP_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [imu_avg_pkg::PHASE_BITS-1:0] phase_r, phase_nxt;
  imu_avg_pkg::axis_vec_t             mean_r, mean_nxt;
  logic                               out_valid_r, out_valid_nxt;
  imu_avg_pkg::axis_vec_t             out_mean_r, out_mean_nxt;
  logic [imu_avg_pkg::STAMP_BITS-1:0] out_stamp_r, out_stamp_nxt;
  logic                               div_done;
  logic [imu_avg_pkg::SAMPLE_BITS-1:0] div_quo;
  imu_avg_pkg::sum_vec_t              sums_acc;
  logic [imu_avg_pkg::PHASE_BITS:0]   phase_sum;

  imu_avg_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sums_r[cmd.axis]),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    logic [imu_avg_pkg::SUM_BITS:0] wide;
    for (int i = 0; i < imu_avg_pkg::AXES; i++) begin
      wide = {sums_r[i][imu_avg_pkg::SUM_BITS-1], sums_r[i]}
           + {{(imu_avg_pkg::COUNT_BITS+1){samples[i][imu_avg_pkg::SAMPLE_BITS-1]}},
              samples[i]};
      if (wide[imu_avg_pkg::SUM_BITS] != wide[imu_avg_pkg::SUM_BITS-1]) begin
        sums_acc[i] = wide[imu_avg_pkg::SUM_BITS] ? imu_avg_pkg::SUM_MIN
                                                  : imu_avg_pkg::SUM_MAX;
      end else begin
        sums_acc[i] = wide[imu_avg_pkg::SUM_BITS-1:0];
      end
    end
  end

  assign phase_sum = {1'b0, phase_r} + (imu_avg_pkg::PHASE_BITS+1)'(tick_r);

  always_comb begin
    tick_nxt      = tick_r;
    period_nxt    = period_r;
    sums_nxt      = sums_r;
    count_nxt     = count_r;
    elapsed_nxt   = elapsed_r;
    phase_nxt     = phase_r;
    mean_nxt      = mean_r;
    out_valid_nxt = out_valid_r;
    out_mean_nxt  = out_mean_r;
    out_stamp_nxt = out_stamp_r;

    if (cfg_we) begin
      case (cfg_index)
        imu_avg_pkg::CFG_IDX_TICK:   tick_nxt = cfg_data;
        imu_avg_pkg::CFG_IDX_OUTPUT: period_nxt = cfg_data;
        default: ;
      endcase
    end

    if (cmd.accum) begin
      sums_nxt = sums_acc;
      if (count_r != imu_avg_pkg::COUNT_MAX) begin
        count_nxt = count_r + imu_avg_pkg::COUNT_BITS'(1);
      end
      elapsed_nxt = elapsed_r + imu_avg_pkg::STAMP_BITS'(tick_r);
      phase_nxt   = phase_sum[imu_avg_pkg::PHASE_BITS] ? imu_avg_pkg::PHASE_MAX
                                                      : phase_sum[imu_avg_pkg::PHASE_BITS-1:0];
    end

    if (cmd.store_mean) begin
      mean_nxt[cmd.axis] = div_quo;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      out_mean_nxt  = mean_r;
      out_stamp_nxt = elapsed_r;
      sums_nxt      = '0;
      count_nxt     = '0;
      phase_nxt     = phase_r - imu_avg_pkg::PHASE_BITS'(period_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= imu_avg_pkg::TICK_RESET;
      period_r    <= imu_avg_pkg::OUTPUT_RESET;
      sums_r      <= '0;
      count_r     <= '0;
      elapsed_r   <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tick_r      <= tick_nxt;
      period_r    <= period_nxt;
      sums_r      <= sums_nxt;
      count_r     <= count_nxt;
      elapsed_r   <= elapsed_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mean_r      <= mean_nxt;
    out_mean_r  <= out_mean_nxt;
    out_stamp_r <= out_stamp_nxt;
  end

  assign status.emit     = (phase_r >= imu_avg_pkg::PHASE_BITS'(period_r));
  assign status.div_done = div_done;
  assign status.out_full = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_means = out_mean_r;
  assign out_stamp = out_stamp_r;

endmodule

`default_nettype wire

// ----- rtl/core/imu_avg_ctrl.sv -----
// ----------------------------------------------------------------------------
// imu_avg_ctrl
// Sequencer: accepts a sample, checks the phase and walks the divider over
// the six axes before handing the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_avg_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire imu_avg_pkg::dp_status_t status,
  output imu_avg_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_CHECK     = 5'b00010,
    S_DIV_START = 5'b00100,
    S_DIV_WAIT  = 5'b01000,
    S_LOAD      = 5'b10000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [imu_avg_pkg::AXIS_BITS-1:0] axis_r, axis_nxt;

  always_comb begin
    state_nxt      = state_r;
    axis_nxt       = axis_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.axis       = axis_r;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.accum = in_valid;
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        axis_nxt  = '0;
        state_nxt = status.emit ? S_DIV_START : S_IDLE;
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.store_mean = 1'b1;
          if (axis_r == imu_avg_pkg::AXIS_LAST) begin
            state_nxt = S_LOAD;
          end else begin
            axis_nxt  = axis_r + imu_avg_pkg::AXIS_BITS'(1);
            state_nxt = S_DIV_START;
          end
        end
      end
      S_LOAD: begin
        if (!status.out_full) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/imu_average_decimator_top.sv -----
// ----------------------------------------------------------------------------
// imu_average_decimator_top
// Average-and-dump decimator for three accel and three gyro axes.
// A sample that closes no output period passes the phase check before the next
// one is taken. A sample that closes a period waits for six divisions, one per
// axis, in the shared radix-16 divider. The result sits in an output register,
// so new samples are taken while it waits for its transfer, until the next
// sample that closes a period. Synchronous active-low reset clears all sums,
// counters and the output valid and restores the default periods.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_average_decimator_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  imu_avg_in_if.sink                                in_ch,
  imu_avg_out_if.source                             out_ch,
  input  wire logic                                 cfg_we,
  input  wire logic [imu_avg_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [imu_avg_pkg::CFG_BITS-1:0]     cfg_data
);

  imu_avg_pkg::ctrl_cmd_t  cmd;
  imu_avg_pkg::dp_status_t status;
  imu_avg_pkg::axis_vec_t  samples;
  imu_avg_pkg::axis_vec_t  out_means;
  logic                    in_ready;

  assign samples[0] = in_ch.accel_x;
  assign samples[1] = in_ch.accel_y;
  assign samples[2] = in_ch.accel_z;
  assign samples[3] = in_ch.rate_x;
  assign samples[4] = in_ch.rate_y;
  assign samples[5] = in_ch.rate_z;

  assign in_ch.ready = in_ready;

  imu_avg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  imu_avg_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_means (out_means),
    .out_stamp (out_ch.stamp_us)
  );

  assign out_ch.mean_accel_x = out_means[0];
  assign out_ch.mean_accel_y = out_means[1];
  assign out_ch.mean_accel_z = out_means[2];
  assign out_ch.mean_rate_x  = out_means[3];
  assign out_ch.mean_rate_y  = out_means[4];
  assign out_ch.mean_rate_z  = out_means[5];

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !status.out_full)
    else $error("result loaded while a previous result is still pending");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_ch.valid)
    else $error("loaded result not presented on the output channel");

  a_one_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("second sample taken before the phase check");

  a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !in_ready)
    else $error("divider started while the input side is open");
`endif

endmodule

`default_nettype wire
